[rtl/core/bae_pkg.sv]
// Shared constants, types and controller commands of the binary arithmetic encoder.
`default_nettype none

package bae_pkg;

  // Coder precision and counter widths
  localparam int PRECISION = 32;
  localparam int PEND_W    = 8;
  localparam int PROB_W    = 32;
  localparam int SYM_W     = 8;
  localparam int NUM_DEC   = 2 * SYM_W;
  localparam int DEC_W     = $clog2(NUM_DEC + 1);
  localparam int MAX_BYTES = 64;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 3;

  localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'(64'h8000_0000);
  localparam logic [PROB_W-1:0] VAL_MASK   = PROB_W'((64'd1 << PRECISION) - 64'd1);
  localparam logic [PEND_W-1:0] PEND_MAX   = {PEND_W{1'b1}};
  localparam logic [CNT_W-1:0]  BYTE_LIMIT = CNT_W'(MAX_BYTES);
  localparam logic [DEC_W-1:0]  DEC_LAST   = DEC_W'(NUM_DEC);
  localparam logic [POS_W-1:0]  POS_TOP    = {POS_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MID,
    ST_RENORM,
    ST_PEND,
    ST_TERM,
    ST_TPEND,
    ST_TPAD,
    ST_DONE
  } bae_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic decide;
    logic renorm;
    logic pend;
    logic term;
    logic pad;
    logic finish;
  } bae_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic range_ge_half;
    logic emit_case;
    logic pend_nz;
    logic pend_one;
    logic dec_done;
    logic flush;
    logic stall;
    logic out_free;
  } bae_status_t;

endpackage

`default_nettype wire

[rtl/core/bae_ctrl.sv]
// Sequencing state machine of the binary arithmetic encoder.
`default_nettype none

module bae_ctrl
  import bae_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  bae_status_t  status,
  output bae_cmd_t     cmd
);

  bae_state_t state;
  bae_state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next step and issue its command
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MID;
      end
      ST_MID: begin
        cmd.decide = 1'b1;
        state_next = ST_RENORM;
      end
      ST_RENORM: begin
        if (status.range_ge_half) begin
          if (!status.dec_done) begin
            state_next = ST_MUL;
          end else if (status.flush) begin
            state_next = ST_TERM;
          end else begin
            state_next = ST_DONE;
          end
        end else if (!status.stall) begin
          cmd.renorm = 1'b1;
          if (status.emit_case && status.pend_nz) begin
            state_next = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        if (!status.stall) begin
          cmd.pend = 1'b1;
          if (status.pend_one) begin
            state_next = ST_RENORM;
          end
        end
      end
      ST_TERM: begin
        if (!status.stall) begin
          cmd.term   = 1'b1;
          state_next = ST_TPEND;
        end
      end
      ST_TPEND: begin
        if (!status.stall) begin
          cmd.pend = 1'b1;
          if (status.pend_one) begin
            state_next = ST_TPAD;
          end
        end
      end
      ST_TPAD: begin
        if (!status.stall) begin
          cmd.pad    = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/bae_datapath.sv]
// Interval registers, split multiplier, bit packer and output stage of the encoder.
`default_nettype none

module bae_datapath
  import bae_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  input  wire [PROB_W-1:0]     cfg_data,
  input  wire [2*SYM_W-1:0]    s_tdata,
  input  wire                  s_tuser,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [BYTE_W-1:0]    m_tdata,
  output logic                 m_tlast,
  input  bae_cmd_t             cmd,
  output bae_status_t          status
);

  localparam int TOP = PRECISION - 1;

  logic [PROB_W-1:0]    prob;
  logic [PRECISION-1:0] low;
  logic [PRECISION-1:0] range;
  logic                 carry;
  logic [PEND_W-1:0]    pend;
  logic [POS_W-1:0]     pos;
  logic [BYTE_W-1:0]    shifter;
  logic [2*SYM_W-1:0]   sym;
  logic                 flush;
  logic [DEC_W-1:0]     dec_cnt;
  logic [2*PROB_W-1:0]  prod;
  logic                 emit_bit;
  logic [BYTE_W-1:0]    held;
  logic                 held_valid;
  logic [CNT_W-1:0]     byte_cnt;

  logic [PROB_W-1:0]    range_ext;
  logic [PROB_W-1:0]    low_ext;
  logic [2*PROB_W-1:0]  mid_sum;
  logic [PROB_W-1:0]    mid;
  logic                 low_ovf;
  logic [PRECISION-1:0] low_add;
  logic [PRECISION-1:0] range_sub;
  logic [PRECISION-1:0] range_zero;
  logic [PEND_W-1:0]    pend_inc;
  logic                 emit_en;
  logic                 emit_val;
  logic [BYTE_W-1:0]    shifter_or;
  logic [POS_W-1:0]     pos_inc;
  logic                 byte_put;
  logic [BYTE_W-1:0]    byte_val;

  // Split arithmetic
  assign range_ext  = PROB_W'(range);
  assign low_ext    = PROB_W'(low);
  assign mid_sum    = prod + {{PROB_W{1'b0}}, prob};
  assign mid        = mid_sum[2*PROB_W-1:PROB_W];
  assign low_ovf    = mid > (VAL_MASK - low_ext);
  assign low_add    = PRECISION'(low_ext + mid);
  assign range_sub  = PRECISION'(range_ext - mid);
  assign range_zero = PRECISION'(mid - PROB_W'(1));
  assign pend_inc   = (pend == PEND_MAX) ? pend : pend + PEND_W'(1);

  // Select the bit to emit this cycle
  always_comb begin
    emit_en  = 1'b0;
    emit_val = 1'b0;
    if (cmd.renorm) begin
      emit_en  = carry | ~low[TOP];
      emit_val = carry;
    end else if (cmd.term) begin
      emit_en  = 1'b1;
      emit_val = carry | low[TOP];
    end else if (cmd.pend) begin
      emit_en  = 1'b1;
      emit_val = ~emit_bit;
    end
  end

  // Pack bits into the byte shifter
  assign shifter_or = emit_val ? (shifter | 8'h80) : shifter;
  assign pos_inc    = pos + POS_W'(1);
  assign byte_put   = (emit_en && (pos_inc == '0)) || cmd.pad;
  assign byte_val   = cmd.pad ? (shifter >> (POS_TOP - pos)) : shifter_or;

  always_ff @(posedge clk) begin
    if (rst) begin
      prob       <= PROB_RESET;
      low        <= '0;
      range      <= '0;
      carry      <= 1'b0;
      pend       <= '0;
      pos        <= '0;
      shifter    <= '0;
      held_valid <= 1'b0;
      byte_cnt   <= '0;
      m_tvalid   <= 1'b0;
      dec_cnt    <= '0;
    end else begin
      if (cfg_valid) begin
        prob <= cfg_data;
      end

      // Latch the beat
      if (cmd.load) begin
        sym     <= s_tdata;
        flush   <= s_tuser;
        dec_cnt <= '0;
      end

      if (cmd.mul) begin
        prod <= (2*PROB_W)'(range_ext) * (2*PROB_W)'(prob);
      end

      // Code one decision
      if (cmd.decide) begin
        if (sym[0]) begin
          range <= range_sub;
          low   <= low_add;
          if (low_ovf) begin
            carry <= 1'b1;
          end
        end else begin
          range <= range_zero;
        end
        sym     <= sym >> 1;
        dec_cnt <= dec_cnt + DEC_W'(1);
      end

      // One renormalization step
      if (cmd.renorm) begin
        if (carry) begin
          carry <= low[TOP];
        end else if (low[TOP]) begin
          pend <= pend_inc;
        end
        emit_bit <= emit_val;
        low      <= low << 1;
        range    <= {range[PRECISION-2:0], 1'b1};
      end

      if (cmd.pend) begin
        pend <= pend - PEND_W'(1);
      end

      if (cmd.term) begin
        pend     <= pend_inc;
        emit_bit <= emit_val;
      end

      // Advance the bit packer
      if (emit_en) begin
        pos     <= pos_inc;
        shifter <= (pos_inc == '0) ? '0 : (shifter_or >> 1);
      end

      // Keep one byte back so the last one of the item can be marked
      if (byte_put && (byte_cnt < BYTE_LIMIT)) begin
        held       <= byte_val;
        held_valid <= 1'b1;
        byte_cnt   <= byte_cnt + CNT_W'(1);
      end

      // Present the held byte, or drain the output register
      if (byte_put && (byte_cnt < BYTE_LIMIT) && held_valid) begin
        m_tdata  <= held;
        m_tlast  <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (cmd.finish && held_valid) begin
        m_tdata  <= held;
        m_tlast  <= 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Return to the start of a new stream
      if (cmd.pad) begin
        low     <= '0;
        range   <= '0;
        carry   <= 1'b0;
        pend    <= '0;
        pos     <= '0;
        shifter <= '0;
      end

      // Close the item after its last byte is released
      if (cmd.finish) begin
        held_valid <= 1'b0;
        byte_cnt   <= '0;
      end
    end
  end

  // Report to the controller
  assign status.range_ge_half = range[TOP];
  assign status.emit_case     = carry | ~low[TOP];
  assign status.pend_nz       = pend != '0;
  assign status.pend_one      = pend == PEND_W'(1);
  assign status.dec_done      = dec_cnt == DEC_LAST;
  assign status.flush         = flush;
  assign status.stall         = held_valid & m_tvalid & ~m_tready;
  assign status.out_free      = ~m_tvalid | m_tready;

endmodule

`default_nettype wire

[rtl/core/binary_arithmetic_encoder.sv]
// Top level of the binary arithmetic encoder: controller plus datapath.
// Each decision steps through multiply, split and range check, followed by any renormalization
// shifts and pending bits released; an item is accepted, coded and finished in turn.
// A flush adds termination, its pending drain and the pad; a waiting output byte stalls them.
// Items are coded one at a time: a new item is accepted only while idle.
// Reset: rst (synchronous) clears the interval, counters and output; probability 0x80000000.
`default_nettype none

module binary_arithmetic_encoder
  import bae_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [PROB_W-1:0]   cfg_data,   // zero_probability
  input  wire                s_tvalid,
  output logic               s_tready,
  input  wire [2*SYM_W-1:0]  s_tdata,    // first_symbol [7:0], second_symbol [15:8]
  input  wire                s_tuser,    // flush
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [BYTE_W-1:0]  m_tdata,    // code_byte [7:0]
  output logic               m_tlast     // last_of_run
);

  bae_cmd_t    cmd;
  bae_status_t status;

  // Configuration is taken at any time
  assign cfg_ready = 1'b1;

  bae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bae_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
